>>> sv/pbd_dc_pkg.sv
package pbd_dc_pkg;

   // Field widths of the streams and registers.
   localparam int COORD_W     = 32;
   localparam int MASS_W      = 24;
   localparam int LEN_W       = 32;
   localparam int RATIO_W     = 16;
   localparam int STIFF_W     = 17;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 8;

   localparam int REQ_DATA_W = 6 * COORD_W + 2 * MASS_W + LEN_W;
   localparam int RSP_DATA_W = 6 * COORD_W;

   // Internal datapath widths.
   localparam int DIFF_W     = COORD_W + 1;
   localparam int DMAG_W     = COORD_W;
   localparam int SQ_W       = 2 * DMAG_W;
   localparam int SUMSQ_W    = SQ_W + 2;
   localparam int DIST_W     = 35;
   localparam int PROD_W     = RATIO_W + LEN_W;
   localparam int WSUM_W     = MASS_W + 1;
   localparam int FRAC_W     = 16;
   localparam int SH_NUM_W   = MASS_W + FRAC_W;
   localparam int SHARE_W    = 17;
   localparam int GAIN_W     = 17;
   localparam int ERR_W      = DIST_W + 1;
   localparam int ERR_MAG_W  = DIST_W;
   localparam int EPROD_W    = ERR_MAG_W + GAIN_W;
   localparam int EMAG_W     = EPROD_W - FRAC_W;
   localparam int U_FRAC_W   = 28;
   localparam int U_W        = U_FRAC_W + 1;
   localparam int U_NUM_W    = DMAG_W + U_FRAC_W;
   localparam int MPROD_W    = EMAG_W + U_W;
   localparam int MOVE_W     = MPROD_W - U_FRAC_W;
   localparam int POS_W      = MOVE_W + 2;

   // Pipeline latencies; the square root and dividers retire one bit per stage.
   localparam int LAT_SHARE = SHARE_W;
   localparam int LAT_SQRT  = DIST_W;
   localparam int LAT_U     = U_W;
   localparam int ITEM_DLY  = LAT_SQRT + 2;
   localparam int GAIN_DLY  = LAT_SQRT + 1 - LAT_SHARE;
   localparam int CORR_DLY  = LAT_U - 1;
   localparam int TOTAL_LAT = LAT_SQRT + LAT_U + 5;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_APPLIED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BROKEN  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STATIC  = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAK_RATIO = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STIFFNESS   = 8'd1;

   localparam logic [RATIO_W-1:0] BREAK_RATIO_RESET = 16'd307;
   localparam logic [STIFF_W-1:0] STIFFNESS_RESET   = 17'd65536;

   // Operands carried from the input stage to the square root output.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] p1;
      logic [2:0][COORD_W-1:0] p2;
      logic [2:0][DMAG_W-1:0]  dmag;
      logic [2:0]              dneg;
      logic [LEN_W-1:0]        rest;
      logic [PROD_W-1:0]       brprod;
      logic                    wzero;
   } item_type;

   // Decision and error terms carried alongside the unit vector dividers.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] p1;
      logic [2:0][COORD_W-1:0] p2;
      logic [2:0]              dneg;
      logic [STATUS_W-1:0]     status;
      logic                    fix;
      logic                    eneg;
      logic [EMAG_W-1:0]       emag1;
      logic [EMAG_W-1:0]       emag2;
   } corr_type;

   // Clamp a wide signed position to signed Q16.16.
   function automatic logic [COORD_W-1:0] sat_coord(input logic [POS_W-1:0] v);
      logic [COORD_W-1:0] r;
      if (v[POS_W-1:COORD_W-1] == '0 || v[POS_W-1:COORD_W-1] == '1) begin
         r = v[COORD_W-1:0];
      end else if (v[POS_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

>>> sv/pbd_dc_sqrt.sv
// Pipelined integer square root: one root bit per stage, floor result.
module pbd_dc_sqrt #(
   parameter int IN_W  = 66,
   parameter int OUT_W = 35
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [IN_W-1:0]  radicand,
   output logic [OUT_W-1:0] root
);

   localparam int RAD_W = 2 * OUT_W;
   localparam int REM_W = OUT_W + 2;

   logic [RAD_W-1:0] rad_ff [OUT_W-1];
   logic [OUT_W-1:0] root_ff [OUT_W];
   logic [REM_W-1:0] rem_ff [OUT_W];

   logic [RAD_W-1:0] src_rad [OUT_W];
   logic [OUT_W-1:0] src_root [OUT_W];
   logic [REM_W-1:0] src_rem [OUT_W];

   assign src_rad[0]  = RAD_W'(radicand);
   assign src_root[0] = '0;
   assign src_rem[0]  = '0;

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      logic             take;

      if (k > 0) begin : g_link
         assign src_rad[k]  = rad_ff[k-1];
         assign src_root[k] = root_ff[k-1];
         assign src_rem[k]  = rem_ff[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign shifted = {src_rem[k][OUT_W-1:0], src_rad[k][RAD_W-1 -: 2]};
      assign trial   = {src_root[k], 2'b01};
      assign take    = shifted >= trial;

      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[k] <= {src_root[k][OUT_W-2:0], take};
            rem_ff[k]  <= take ? shifted - trial : shifted;
         end
      end

      if (k < OUT_W - 1) begin : g_rad
         always_ff @(posedge clock) begin
            if (enable) begin
               rad_ff[k] <= src_rad[k] << 2;
            end
         end
      end
   end

   assign root = root_ff[OUT_W-1];

endmodule

>>> sv/pbd_dc_div.sv
// Pipelined restoring divider: one quotient bit per stage. The quotient must
// fit in Q_W bits; a zero divisor gives a meaningless quotient.
module pbd_dc_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 25,
   parameter int Q_W   = 17
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   logic [Q_W-1:0]   lo_ff [Q_W];
   logic [DEN_W-1:0] rem_ff [Q_W-1];
   logic [DEN_W-1:0] den_ff [Q_W-1];

   logic [Q_W-1:0]   src_lo [Q_W];
   logic [DEN_W-1:0] src_rem [Q_W];
   logic [DEN_W-1:0] src_den [Q_W];

   assign src_lo[0]  = num[Q_W-1:0];
   assign src_rem[0] = DEN_W'(num[NUM_W-1:Q_W]);
   assign src_den[0] = den;

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [DEN_W:0] trial;
      logic           take;

      if (k > 0) begin : g_link
         assign src_lo[k]  = lo_ff[k-1];
         assign src_rem[k] = rem_ff[k-1];
         assign src_den[k] = den_ff[k-1];
      end

      // Shift in the next dividend bit and subtract where it fits.
      assign trial = {src_rem[k], src_lo[k][Q_W-1]};
      assign take  = trial >= {1'b0, src_den[k]};

      always_ff @(posedge clock) begin
         if (enable) begin
            lo_ff[k] <= {src_lo[k][Q_W-2:0], take};
         end
      end

      if (k < Q_W - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= take ? DEN_W'(trial - {1'b0, src_den[k]}) : DEN_W'(trial);
               den_ff[k] <= src_den[k];
            end
         end
      end
   end

   assign quo = lo_ff[Q_W-1];

endmodule

>>> sv/pbd_distance_constraint_project.sv
// Breakable distance constraint projection for a position based dynamics
// solver. One constraint enters per clock while the output is not held, and
// its result passes through the 35-stage square root followed by the
// 29-stage unit vector dividers. The whole pipeline advances together and
// holds only while a result sits unaccepted at the output. The result carries
// the corrected positions, or the unchanged inputs with status broken or
// static. Write break_ratio and stiffness_factor only while no constraint is
// in flight.
module pbd_distance_constraint_project
   import pbd_dc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z,
   // first_inv_mass, second_inv_mass, rest_length
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // new_first_x, new_first_y, new_first_z, new_second_x, new_second_y,
   // new_second_z
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // status
   output logic [STATUS_W-1:0]    rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [STIFF_W-1:0]     csr_data
);

   logic                 en;
   logic [TOTAL_LAT-1:0] vld_ff;
   logic [RATIO_W-1:0]   break_ratio_ff;
   logic [STIFF_W-1:0]   stiffness_ff;

   // The pipeline moves whenever the output register is free or drained.
   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         break_ratio_ff <= BREAK_RATIO_RESET;
         stiffness_ff   <= STIFFNESS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BREAK_RATIO: break_ratio_ff <= csr_data[RATIO_W-1:0];
            CSR_STIFFNESS:   stiffness_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Input stage: unpack, differences and the break threshold.
   item_type           in_item;
   logic [MASS_W-1:0]  in_w1;
   logic [MASS_W-1:0]  in_w2;

   always_comb begin
      logic [COORD_W-1:0] c1;
      logic [COORD_W-1:0] c2;
      logic [DIFF_W-1:0]  d;
      for (int i = 0; i < 3; i++) begin
         c1 = req_tdata[i*COORD_W +: COORD_W];
         c2 = req_tdata[(3+i)*COORD_W +: COORD_W];
         d  = {c1[COORD_W-1], c1} - {c2[COORD_W-1], c2};
         in_item.p1[i]   = c1;
         in_item.p2[i]   = c2;
         in_item.dneg[i] = d[DIFF_W-1];
         in_item.dmag[i] = DMAG_W'(d[DIFF_W-1] ? -d : d);
      end
      in_w1          = req_tdata[6*COORD_W +: MASS_W];
      in_w2          = req_tdata[6*COORD_W+MASS_W +: MASS_W];
      in_item.rest   = req_tdata[6*COORD_W+2*MASS_W +: LEN_W];
      in_item.brprod = PROD_W'(break_ratio_ff) * PROD_W'(in_item.rest);
      in_item.wzero  = (in_w1 == '0) && (in_w2 == '0);
   end

   item_type            a_item_ff;
   logic [MASS_W-1:0]   a_w1_ff;
   logic [MASS_W-1:0]   a_w2_ff;
   logic [WSUM_W-1:0]   a_wsum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff <= in_item;
         a_w1_ff   <= in_w1;
         a_w2_ff   <= in_w2;
         a_wsum_ff <= WSUM_W'(in_w1) + WSUM_W'(in_w2);
      end
   end

   // Squares, then their sum.
   logic [SQ_W-1:0]    sq_ff [3];
   logic [SUMSQ_W-1:0] sumsq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_W'(a_item_ff.dmag[i]) * SQ_W'(a_item_ff.dmag[i]);
         end
         sumsq_ff <= SUMSQ_W'(sq_ff[0]) + SUMSQ_W'(sq_ff[1]) + SUMSQ_W'(sq_ff[2]);
      end
   end

   logic [DIST_W-1:0] cur_len;

   pbd_dc_sqrt #(
      .IN_W  (SUMSQ_W),
      .OUT_W (DIST_W)
   ) u_sqrt (
      .clock    (clock),
      .enable   (en),
      .radicand (sumsq_ff),
      .root     (cur_len)
   );

   // Inverse mass shares, computed beside the square root.
   logic [SHARE_W-1:0] share1;
   logic [SHARE_W-1:0] share2;

   pbd_dc_div #(
      .NUM_W (SH_NUM_W),
      .DEN_W (WSUM_W),
      .Q_W   (SHARE_W)
   ) u_share1 (
      .clock  (clock),
      .enable (en),
      .num    ({a_w1_ff, {FRAC_W{1'b0}}}),
      .den    (a_wsum_ff),
      .quo    (share1)
   );

   pbd_dc_div #(
      .NUM_W (SH_NUM_W),
      .DEN_W (WSUM_W),
      .Q_W   (SHARE_W)
   ) u_share2 (
      .clock  (clock),
      .enable (en),
      .num    ({a_w2_ff, {FRAC_W{1'b0}}}),
      .den    (a_wsum_ff),
      .quo    (share2)
   );

   // Shares scaled by the stiffness factor.
   logic [SHARE_W+STIFF_W-1:0] gp1;
   logic [SHARE_W+STIFF_W-1:0] gp2;
   logic [1:0][GAIN_W-1:0]     gain_ff;
   logic [1:0][GAIN_W-1:0]     gain_dly_ff [GAIN_DLY];

   assign gp1 = (SHARE_W+STIFF_W)'(share1) * (SHARE_W+STIFF_W)'(stiffness_ff);
   assign gp2 = (SHARE_W+STIFF_W)'(share2) * (SHARE_W+STIFF_W)'(stiffness_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         gain_ff[0]     <= gp1[GAIN_W+FRAC_W-1:FRAC_W];
         gain_ff[1]     <= gp2[GAIN_W+FRAC_W-1:FRAC_W];
         gain_dly_ff[0] <= gain_ff;
         for (int k = 1; k < GAIN_DLY; k++) begin
            gain_dly_ff[k] <= gain_dly_ff[k-1];
         end
      end
   end

   // Operand line that meets the square root result.
   item_type item_dly_ff [ITEM_DLY];

   always_ff @(posedge clock) begin
      if (en) begin
         item_dly_ff[0] <= a_item_ff;
         for (int k = 1; k < ITEM_DLY; k++) begin
            item_dly_ff[k] <= item_dly_ff[k-1];
         end
      end
   end

   // Decision stage: break test, status and scaled length error.
   item_type               d_item;
   logic [1:0][GAIN_W-1:0] d_gain;
   logic [ERR_W-1:0]       d_err;
   logic [ERR_MAG_W-1:0]   d_errmag;
   logic [EPROD_W-1:0]     d_ep1;
   logic [EPROD_W-1:0]     d_ep2;
   logic                   d_broken;
   corr_type               corr_in;

   assign d_item   = item_dly_ff[ITEM_DLY-1];
   assign d_gain   = gain_dly_ff[GAIN_DLY-1];
   assign d_err    = ERR_W'(cur_len) - ERR_W'(d_item.rest);
   assign d_errmag = ERR_MAG_W'(d_err[ERR_W-1] ? -d_err : d_err);
   assign d_ep1    = EPROD_W'(d_errmag) * EPROD_W'(d_gain[0]);
   assign d_ep2    = EPROD_W'(d_errmag) * EPROD_W'(d_gain[1]);
   assign d_broken = PROD_W'({cur_len, 8'b0}) > d_item.brprod;

   always_comb begin
      corr_in.p1    = d_item.p1;
      corr_in.p2    = d_item.p2;
      corr_in.dneg  = d_item.dneg;
      corr_in.eneg  = d_err[ERR_W-1];
      corr_in.emag1 = d_ep1[EPROD_W-1:FRAC_W];
      corr_in.emag2 = d_ep2[EPROD_W-1:FRAC_W];
      if (d_broken) begin
         corr_in.status = STATUS_BROKEN;
      end else if (d_item.wzero) begin
         corr_in.status = STATUS_STATIC;
      end else begin
         corr_in.status = STATUS_APPLIED;
      end
      corr_in.fix = !d_broken && !d_item.wzero && (cur_len != '0);
   end

   corr_type corr_ff;
   corr_type corr_dly_ff [CORR_DLY];

   always_ff @(posedge clock) begin
      if (en) begin
         corr_ff        <= corr_in;
         corr_dly_ff[0] <= corr_ff;
         for (int k = 1; k < CORR_DLY; k++) begin
            corr_dly_ff[k] <= corr_dly_ff[k-1];
         end
      end
   end

   // Unit vector components in Q1.28.
   logic [U_W-1:0] um [3];

   for (genvar i = 0; i < 3; i++) begin : g_unit
      pbd_dc_div #(
         .NUM_W (U_NUM_W),
         .DEN_W (DIST_W),
         .Q_W   (U_W)
      ) u_unit (
         .clock  (clock),
         .enable (en),
         .num    ({d_item.dmag[i], {U_FRAC_W{1'b0}}}),
         .den    (cur_len),
         .quo    (um[i])
      );
   end

   // Movement magnitudes for both particles.
   corr_type          e_corr_ff;
   logic [MOVE_W-1:0] move_ff [2][3];
   corr_type          e_src;

   assign e_src = corr_dly_ff[CORR_DLY-1];

   always_ff @(posedge clock) begin
      logic [MPROD_W-1:0] mp1;
      logic [MPROD_W-1:0] mp2;
      if (en) begin
         e_corr_ff <= e_src;
         for (int i = 0; i < 3; i++) begin
            mp1 = MPROD_W'(e_src.emag1) * MPROD_W'(um[i]);
            mp2 = MPROD_W'(e_src.emag2) * MPROD_W'(um[i]);
            move_ff[0][i] <= mp1[MPROD_W-1:U_FRAC_W];
            move_ff[1][i] <= mp2[MPROD_W-1:U_FRAC_W];
         end
      end
   end

   // Output register: apply the moves and saturate.
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [STATUS_W-1:0]   rsp_tuser_ff;

   always_ff @(posedge clock) begin
      logic [POS_W-1:0] pos1;
      logic [POS_W-1:0] pos2;
      logic [POS_W-1:0] mv1;
      logic [POS_W-1:0] mv2;
      logic             neg;
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pos1 = POS_W'($signed(e_corr_ff.p1[i]));
            pos2 = POS_W'($signed(e_corr_ff.p2[i]));
            mv1  = e_corr_ff.fix ? POS_W'(move_ff[0][i]) : '0;
            mv2  = e_corr_ff.fix ? POS_W'(move_ff[1][i]) : '0;
            neg  = e_corr_ff.eneg ^ e_corr_ff.dneg[i];
            rsp_tdata_ff[i*COORD_W +: COORD_W]     <= sat_coord(neg ? pos1 + mv1 : pos1 - mv1);
            rsp_tdata_ff[(3+i)*COORD_W +: COORD_W] <= sat_coord(neg ? pos2 - mv2 : pos2 + mv2);
         end
         rsp_tuser_ff <= e_corr_ff.status;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

   // Checks.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_APPLIED || rsp_tuser == STATUS_BROKEN ||
                      rsp_tuser == STATUS_STATIC))
      else $error("result status code out of range");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while the output is held");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      en |=> (rsp_tvalid == $past(vld_ff[TOTAL_LAT-2])))
      else $error("output valid lost step with the pipeline");

   a_fix_status: assert property (@(posedge clock) disable iff (reset)
      corr_ff.fix |-> (corr_ff.status == STATUS_APPLIED))
      else $error("correction scheduled for a broken or static pair");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
